@@ rtl/hiq_pkg.sv @@
// ----------------------------------------------------------------------------
// hiq_pkg
// Shared types, constants and helpers for the quadratic probing hash insert.
// ----------------------------------------------------------------------------
package hiq_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 10;

    // Stream payload widths; both tdata widths are padded to whole bytes.
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 1;

    // Configuration port.
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int CFG_IDX_W   = PADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_TBL_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0]    TBL_SIZE_RST = 11'd1021;

    // Modulo unit: remainder bits resolved per cycle.
    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } t_mod_rsp;

    // Clamp the programmed size into the range the table supports.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
        logic [SIZE_W-1:0] s;
        s = ts;
        if (s < SIZE_W'(2)) begin
            s = SIZE_W'(2);
        end else if (s > SIZE_W'(TABLE_DEPTH)) begin
            s = SIZE_W'(TABLE_DEPTH);
        end
        return s;
    endfunction

    // (a + b) mod s for a, b already below s.
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0]  a,
                                                 input logic [IDX_W-1:0]  b,
                                                 input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] sum;
        sum = SIZE_W'(a) + SIZE_W'(b);
        if (sum >= s) begin
            sum = sum - s;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/hiq_mod.sv @@
// ----------------------------------------------------------------------------
// hiq_mod
// Iterative key modulo table size, several restoring steps per cycle.
// ----------------------------------------------------------------------------
module hiq_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hiq_pkg::t_mod_req i_req,
    output hiq_pkg::t_mod_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [hiq_pkg::MOD_CNT_W-1:0]   r_cnt;
    logic [hiq_pkg::KEY_W-1:0]       r_dvd;
    logic [hiq_pkg::IDX_W-1:0]       r_rem;
    logic [hiq_pkg::SIZE_W-1:0]      r_div;
    logic [hiq_pkg::IDX_W-1:0]       n_rem;

    // The partial remainder stays below the divisor, so each shifted value
    // is below twice the divisor and one conditional subtract suffices.
    always_comb begin
        logic [hiq_pkg::SIZE_W-1:0] t;
        n_rem = r_rem;
        for (int k = 0; k < hiq_pkg::MOD_BITS; k++) begin
            t = {n_rem, r_dvd[hiq_pkg::KEY_W-1-k]};
            if (t >= r_div) begin
                t = t - r_div;
            end
            n_rem = t[hiq_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hiq_pkg::MOD_CNT_W'(hiq_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << hiq_pkg::MOD_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/hash_insert_quadratic_probe.sv @@
// ----------------------------------------------------------------------------
// hash_insert_quadratic_probe
// Open addressing hash insert with quadratic probing over an occupancy RAM.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata[31:0] key
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata[9:0] slot, tuser[0] failed
// apb       in         psel/penable/pwrite, pready=1    reg 0 at 0x0: tbl_size[10:0]
//
// One key is processed at a time. The modulo unit resolves four remainder bits
// per cycle, and its remainder is registered as the home slot as S_DIV ends.
// S_FETCH then reads the home slot, and each probe in S_LOOK is one read of
// the occupancy RAM read port. Once a probe finds a free slot or the probes
// are used up, the result goes into the result register, or waits in S_HOLD
// while that register is still full, and the next key is accepted in S_IDLE.
// After reset a clearing pass zeroes every entry of the occupancy RAM while
// s_axis is held off; configuration writes are taken throughout.
// The result register lets the next key be accepted while a result waits.

module hash_insert_quadratic_probe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream, tdata: key[31:0].
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [hiq_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // Output stream, tdata: slot[9:0], zero padding above.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [hiq_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // Output stream, tuser: failed[0].
    output logic [hiq_pkg::M_TUSER_W-1:0]     o_m_axis_tuser,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hiq_pkg::PADDR_W-1:0]       paddr,
    input  logic [hiq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hiq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_FETCH = 6'b001000,
        S_LOOK  = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;

    // Configuration.
    logic [hiq_pkg::SIZE_W-1:0]      r_tbl_size;
    logic [hiq_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic                            cfg_wr;

    // Probe sequencing. Probe i visits (home + i*i mod S) mod S. The square
    // is kept incrementally: (i+1)^2 = i^2 + (2i+1), all terms reduced mod S.
    logic [hiq_pkg::SIZE_W-1:0]      r_size;
    logic [hiq_pkg::IDX_W-1:0]       r_home;
    logic [hiq_pkg::IDX_W-1:0]       r_addr;
    logic [hiq_pkg::IDX_W-1:0]       r_sq;
    logic [hiq_pkg::IDX_W-1:0]       r_odd;
    logic [hiq_pkg::SIZE_W-1:0]      r_i;
    logic [hiq_pkg::IDX_W-1:0]       sq_next;
    logic [hiq_pkg::IDX_W-1:0]       odd_next;
    logic [hiq_pkg::IDX_W-1:0]       addr_next;

    // Occupancy RAM.
    logic                            r_occ_mem [hiq_pkg::TABLE_DEPTH];
    logic                            r_rd_data;
    logic [hiq_pkg::IDX_W-1:0]       rd_addr;
    logic                            mem_we;
    logic [hiq_pkg::IDX_W-1:0]       mem_waddr;
    logic                            mem_wdata;
    logic [hiq_pkg::IDX_W-1:0]       r_clr;

    // Results.
    logic                            r_out_valid;
    logic [hiq_pkg::SLOT_W-1:0]      r_out_slot;
    logic                            r_out_failed;
    logic [hiq_pkg::SLOT_W-1:0]      r_pend_slot;
    logic                            r_pend_failed;

    logic                            in_beat;
    logic                            out_free;
    logic                            probe_hit;
    logic                            probe_miss_all;
    logic                            finish;
    logic [hiq_pkg::SLOT_W-1:0]      fin_slot;
    logic                            out_load;
    logic [hiq_pkg::SLOT_W-1:0]      out_load_slot;
    logic                            out_load_failed;

    hiq_pkg::t_mod_req               mod_req;
    hiq_pkg::t_mod_rsp               mod_rsp;

    // ------------------------------------------------------------------
    // Configuration register. The word index is taken from paddr[2];
    // byte offsets within a word are ignored.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[hiq_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_size <= hiq_pkg::TBL_SIZE_RST;
        end else if (cfg_wr && (cfg_idx == hiq_pkg::REG_TBL_SIZE)) begin
            r_tbl_size <= pwdata[hiq_pkg::SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx == hiq_pkg::REG_TBL_SIZE) begin
            prdata = hiq_pkg::APB_DATA_W'(r_tbl_size);
        end
    end

    // ------------------------------------------------------------------
    // Home slot: key modulo the effective size; key and size enter at the input beat.
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    assign mod_req.start    = in_beat;
    assign mod_req.dividend = i_s_axis_tdata[hiq_pkg::KEY_W-1:0];
    assign mod_req.divisor  = hiq_pkg::eff_size(r_tbl_size);

    hiq_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // ------------------------------------------------------------------
    // Probe arithmetic and decision. In S_LOOK the RAM data belongs to
    // r_addr; on a miss the next address is read in the same cycle so
    // that one probe completes per cycle.
    // ------------------------------------------------------------------
    assign sq_next   = hiq_pkg::mod_add(r_sq, r_odd, r_size);
    assign odd_next  = hiq_pkg::mod_add(r_odd, hiq_pkg::IDX_W'(2), r_size);
    assign addr_next = hiq_pkg::mod_add(r_home, sq_next, r_size);

    assign probe_hit      = (r_state == S_LOOK) && !r_rd_data;
    assign probe_miss_all = (r_state == S_LOOK) && r_rd_data && (r_i == r_size);
    assign finish         = probe_hit || probe_miss_all;
    assign fin_slot       = probe_hit ? hiq_pkg::SLOT_W'(r_addr) : '0;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (mod_rsp.done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (finish) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_size <= hiq_pkg::eff_size(r_tbl_size);
        end
        if ((r_state == S_DIV) && mod_rsp.done) begin
            r_home <= mod_rsp.rem;
            r_addr <= mod_rsp.rem;
            r_sq   <= '0;
            r_odd  <= hiq_pkg::IDX_W'(1);
            r_i    <= '0;
        end else if ((r_state == S_LOOK) && !finish) begin
            r_addr <= addr_next;
            r_sq   <= sq_next;
            r_odd  <= odd_next;
            r_i    <= r_i + 1'b1;
        end
        if ((r_state == S_LOOK) && finish) begin
            r_pend_slot   <= fin_slot;
            r_pend_failed <= probe_miss_all;
        end
    end

    // ------------------------------------------------------------------
    // Occupancy RAM: one write port, one registered read port. The slot
    // is marked when a probe finds it free, and the next item's first read
    // comes only after its modulo step, so no forwarding path is needed.
    // ------------------------------------------------------------------
    assign rd_addr   = (r_state == S_LOOK) ? addr_next : r_addr;
    assign mem_we    = (r_state == S_CLEAR) || probe_hit;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign mem_wdata = (r_state != S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_occ_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_comb begin
        out_load        = 1'b0;
        out_load_slot   = fin_slot;
        out_load_failed = probe_miss_all;
        if ((r_state == S_LOOK) && finish && out_free) begin
            out_load = 1'b1;
        end else if ((r_state == S_HOLD) && out_free) begin
            out_load        = 1'b1;
            out_load_slot   = r_pend_slot;
            out_load_failed = r_pend_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_slot   <= out_load_slot;
            r_out_failed <= out_load_failed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = hiq_pkg::M_TDATA_W'(r_out_slot);
    assign o_m_axis_tuser  = hiq_pkg::M_TUSER_W'(r_out_failed);

`ifndef ASSERT_OFF
    // The home slot from the modulo unit is always below the size in use.
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && mod_rsp.done) |-> (hiq_pkg::SIZE_W'(mod_rsp.rem) < r_size))
        else $error("modulo remainder not below table size");

    // Every probed address stays inside the table in use.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> ((hiq_pkg::SIZE_W'(r_addr) < r_size) && (r_i <= r_size)))
        else $error("probe address or count out of range");

    // A failed result carries slot zero.
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_failed) |-> (r_out_slot == '0))
        else $error("failed result with nonzero slot");

    // A found slot is marked occupied in the RAM by the next cycle.
    a_mark_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        probe_hit |=> (r_occ_mem[$past(r_addr)] == 1'b1))
        else $error("chosen slot not marked occupied");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic probing hash insert. Keys stream in
// on the slave side, and a shadow occupancy table predicts the slot or the
// drop for every accepted beat. Each result beat is checked against the
// oldest prediction. The table size is reprogrammed over the APB port only
// when the block is drained, and is read back after every write.
// ----------------------------------------------------------------------------
module testbench;

    // Guard time for the whole run. It covers the slowest legal run, in
    // which every key probes a full 1024-slot table under stalls.
    localparam int GUARD_NS       = 50_000_000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int FINAL_CAP      = 200_000;
    localparam int RANDOM_KEYS    = 550;
    localparam int IDLE_PERCENT   = 37;
    localparam int REPORT_LIMIT   = 10;

    // Register 0 sits at byte address 0. The other index of the address
    // space is not decoded, so writes there must be dropped.
    localparam logic [hiq_pkg::PADDR_W-1:0] TBL_SIZE_ADDR = {hiq_pkg::REG_TBL_SIZE, 2'b00};
    localparam logic [hiq_pkg::PADDR_W-1:0] UNUSED_ADDR   = {~hiq_pkg::REG_TBL_SIZE, 2'b00};

    // Clock, reset and every block input start at a known value.
    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [hiq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [hiq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;
    logic [hiq_pkg::M_TUSER_W-1:0]  o_m_axis_tuser;
    logic                           psel            = 1'b0;
    logic                           penable         = 1'b0;
    logic                           pwrite          = 1'b0;
    logic [hiq_pkg::PADDR_W-1:0]    paddr           = '0;
    logic [hiq_pkg::APB_DATA_W-1:0] pwdata          = '0;
    logic [hiq_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    hash_insert_quadratic_probe i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // key[31:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // slot[9:0], zero padding above
        .o_m_axis_tuser  (o_m_axis_tuser),   // failed[0]
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One expected result beat: where the key lands, or that it was dropped.
    typedef struct {
        logic [hiq_pkg::SLOT_W-1:0] slot;
        logic                       failed;
    } t_placement;

    t_placement                 placements_due[$];
    logic                       slot_taken[hiq_pkg::TABLE_DEPTH];
    logic [hiq_pkg::SIZE_W-1:0] tbl_size_shadow = hiq_pkg::TBL_SIZE_RST;

    // While this is set neither side of the stream inserts idle cycles.
    bit no_idle = 1'b0;

    int mismatches    = 0;
    int keys_sent     = 0;
    int keys_placed   = 0;
    int keys_dropped  = 0;
    int results_seen  = 0;
    int reg_writes    = 0;

    initial begin
        for (int n = 0; n < hiq_pkg::TABLE_DEPTH; n++) begin
            slot_taken[n] = 1'b0;
        end
    end

    // The programmed size is clamped into 2 .. TABLE_DEPTH before use.
    function automatic int unsigned clamp_size(input logic [hiq_pkg::SIZE_W-1:0] raw);
        int unsigned s;
        s = raw;
        if (s < 2) s = 2;
        if (s > hiq_pkg::TABLE_DEPTH) s = hiq_pkg::TABLE_DEPTH;
        return s;
    endfunction

    // Predicts one insert and updates the shadow table. The home slot is
    // tried first, then home + i*i for i from 1 up to the size. A drop
    // leaves the table untouched and reports slot zero.
    function automatic t_placement place_key(input logic [hiq_pkg::KEY_W-1:0] key);
        t_placement  r;
        int unsigned s;
        int unsigned home;
        int unsigned probe;
        int unsigned i;
        s        = clamp_size(tbl_size_shadow);
        home     = key % s;
        r.slot   = '0;
        r.failed = 1'b1;
        if (!slot_taken[home]) begin
            r.slot   = hiq_pkg::SLOT_W'(home);
            r.failed = 1'b0;
        end else begin
            for (i = 1; i <= s && r.failed; i++) begin
                probe = (home + (i * i) % s) % s;
                if (!slot_taken[probe]) begin
                    r.slot   = hiq_pkg::SLOT_W'(probe);
                    r.failed = 1'b0;
                end
            end
        end
        if (!r.failed) slot_taken[r.slot] = 1'b1;
        return r;
    endfunction

    // Only the first few mismatches are printed; all of them are counted.
    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    // The receiver stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        i_m_axis_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Result checker: every accepted result beat is matched against the
    // oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_placement due;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (placements_due.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with nothing expected (tdata %h)",
                                        results_seen, o_m_axis_tdata));
            end else begin
                due = placements_due.pop_front();
                if (o_m_axis_tdata[hiq_pkg::SLOT_W-1:0] !== due.slot)
                    note_mismatch($sformatf("result %0d slot: expected %0d, got %0d",
                                            results_seen, due.slot,
                                            o_m_axis_tdata[hiq_pkg::SLOT_W-1:0]));
                if (o_m_axis_tdata[hiq_pkg::M_TDATA_W-1:hiq_pkg::SLOT_W] !== '0)
                    note_mismatch($sformatf("result %0d tdata padding: expected 0, got %h",
                                  results_seen,
                                  o_m_axis_tdata[hiq_pkg::M_TDATA_W-1:hiq_pkg::SLOT_W]));
                if (o_m_axis_tuser[0] !== due.failed)
                    note_mismatch($sformatf("result %0d failed flag: expected %0b, got %0b",
                                            results_seen, due.failed, o_m_axis_tuser[0]));
            end
        end
    end

    // Sends one key beat. The beat is left up after acceptance so that a
    // following key goes out back to back; the next call replaces or lowers it,
    // or the drain lowers it, at its own falling edge. The prediction is made at
    // the accepting edge, with the configuration in force at that moment.
    task automatic send_key(input logic [hiq_pkg::KEY_W-1:0] key);
        t_placement due;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = key;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        due = place_key(key);
        placements_due = {placements_due, due};
        keys_sent++;
        if (due.failed) keys_dropped++;
        else keys_placed++;
    endtask

    // Holds off the sender until every predicted result has come back, then
    // lets the pipeline settle. A cap keeps each drain bounded.
    task automatic drain_results(input int cap);
        int cycles;
        cycles = 0;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (placements_due.size() != 0 && cycles < cap) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then the access cycle whose rising edge with
    // pready high commits the register.
    task automatic apb_write(input logic [hiq_pkg::PADDR_W-1:0]    addr,
                             input logic [hiq_pkg::APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr[hiq_pkg::PADDR_W-1:2] == hiq_pkg::REG_TBL_SIZE)
            tbl_size_shadow = value[hiq_pkg::SIZE_W-1:0];
        reg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // APB read of the size register, checked against the shadow copy.
    task automatic check_tbl_size;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = TBL_SIZE_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== hiq_pkg::APB_DATA_W'(tbl_size_shadow))
            note_mismatch($sformatf("size readback: expected %0d, got %0d",
                                    tbl_size_shadow, prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes the size and confirms it by reading it back.
    task automatic set_tbl_size(input logic [hiq_pkg::APB_DATA_W-1:0] value);
        apb_write(TBL_SIZE_ADDR, value);
        check_tbl_size();
    endtask

    // Reset value of the size, then inserts at that size: both key extremes,
    // alternating bit patterns, and keys that all share home slot zero so
    // that the probe chain has to step past one, two and then three taken slots.
    task automatic test_reset_size;
        check_tbl_size();
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'd1021);
        send_key(32'd2042);
        send_key(32'd3063);
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);
        drain_results(FINAL_CAP);
    endtask

    // Sizes of zero and one behave as two. Slots zero and one are already
    // taken, so every key here is dropped.
    task automatic test_size_clamp_low;
        set_tbl_size(32'd0);
        send_key(32'd0);
        send_key(32'd1);
        send_key(32'd2);
        drain_results(FINAL_CAP);
        set_tbl_size(32'd1);
        send_key(32'd7);
        drain_results(FINAL_CAP);
    endtask

    // Sizes above the depth behave as the full depth. All three keys map
    // to the top slot, so the probe sequence wraps around past zero.
    task automatic test_size_clamp_high;
        set_tbl_size(32'd2047);
        send_key(32'd1023);
        send_key(32'd2047);
        send_key(32'hFFFF_FFFF);
        drain_results(FINAL_CAP);
        set_tbl_size(32'd1024);
    endtask

    // With a size that is not prime the probe sequence only reaches a few
    // residues, so keys with a shared home run out of slots and drop even
    // though the table has room.
    task automatic test_nonprime_size;
        set_tbl_size(32'd16);
        send_key(32'd0);
        send_key(32'd16);
        send_key(32'd32);
        send_key(32'd48);
        drain_results(FINAL_CAP);
    endtask

    // A write to the undecoded register index must leave the size alone.
    task automatic test_unused_register;
        apb_write(UNUSED_ADDR, 32'd5);
        check_tbl_size();
        send_key(32'd5);
        drain_results(FINAL_CAP);
    endtask

    // Random traffic in phases. Each phase waits for the block to drain,
    // programs a new size and sends a burst of keys. Most keys in a burst
    // share one home slot at the current size, a collision chain, so the
    // probe logic is driven deep; the rest are random keys and repeats.
    task automatic test_random_traffic;
        int                             sent;
        int                             burst;
        int unsigned                    pick;
        int unsigned                    eff;
        logic [hiq_pkg::KEY_W-1:0]      chain_home;
        logic [hiq_pkg::KEY_W-1:0]      prev_key;
        logic [hiq_pkg::KEY_W-1:0]      key;
        logic [hiq_pkg::APB_DATA_W-1:0] size_value;
        int unsigned small_primes[9]  = '{2, 3, 5, 7, 11, 13, 31, 61, 127};
        int unsigned medium_primes[2] = '{251, 509};
        int unsigned large_sizes[3]   = '{1019, 1021, 1024};
        sent     = 0;
        prev_key = '0;
        while (sent < RANDOM_KEYS) begin
            drain_results(FINAL_CAP);
            pick = $urandom_range(0, 99);
            if (pick < 60)      size_value = small_primes[$urandom_range(0, 8)];
            else if (pick < 85) size_value = medium_primes[$urandom_range(0, 1)];
            else if (pick < 93) size_value = large_sizes[$urandom_range(0, 2)];
            else                size_value = $urandom_range(0, 2047);
            // Upper bits of the write data are ignored by the register.
            if ($urandom_range(0, 3) == 0)
                size_value[hiq_pkg::APB_DATA_W-1:hiq_pkg::SIZE_W] =
                    (hiq_pkg::APB_DATA_W - hiq_pkg::SIZE_W)'($urandom);
            set_tbl_size(size_value);
            if ($urandom_range(0, 7) == 0) begin
                apb_write(UNUSED_ADDR, $urandom);
                check_tbl_size();
            end
            eff        = clamp_size(tbl_size_shadow);
            chain_home = $urandom_range(0, eff - 1);
            burst      = $urandom_range(20, 60);
            for (int n = 0; n < burst && sent < RANDOM_KEYS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    key = chain_home + hiq_pkg::KEY_W'(eff) * $urandom_range(0, 4_000_000);
                else if (pick < 85) key = $urandom;
                else                key = prev_key;
                no_idle = (sent >= 200 && sent < 300);
                send_key(key);
                prev_key = key;
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_size();
        test_size_clamp_low();
        test_size_clamp_high();
        test_nonprime_size();
        test_unused_register();
        test_random_traffic();

        drain_results(FINAL_CAP);
        if (placements_due.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", placements_due.size()));
        end

        $display("Inserted %0d keys across %0d register writes: %0d placed, %0d dropped.",
                 keys_sent, reg_writes, keys_placed, keys_dropped);
        $display("Sizes ran from the clamped low end to the full table, with collision chains.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(GUARD_NS);
        $display("Run did not finish in time.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
